FILE: design/assert_macros.svh
// Assertion helpers included by the hasher design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CHECK_PROP(label, clk_i, rst_ni, prop, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define CHECK_NEVER(label, clk_i, rst_ni, cond, msg) \
	`CHECK_PROP(label, clk_i, rst_ni, !(cond), msg)

`endif

FILE: design/sha_pkg.sv
package sha_pkg;

	localparam int WORD_W   = 32;
	localparam int BYTE_W   = 8;
	localparam int FILL_W   = 7;
	localparam int MSG_W    = 61;
	localparam int ROUNDS   = 64;
	localparam int HASH_N   = 8;
	localparam int WIN_N    = 16;

	localparam logic [FILL_W-1:0] BLOCK_BYTES = 7'd64;
	localparam logic [FILL_W-1:0] LEN_POS     = 7'd56;
	localparam logic [BYTE_W-1:0] PAD_BYTE    = 8'h80;

	localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [WORD_W-1:0] INIT_H [HASH_N] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

FILE: design/sha_ifs.sv
interface sha_in_if
	import sha_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              action;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface sha_out_if
	import sha_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] digest_word;
	logic [2:0]        word_index;
	logic              last_word;
	logic              status;

	modport source (output valid, output digest_word, output word_index,
		output last_word, output status, input ready);
	modport sink   (input valid, input digest_word, input word_index,
		input last_word, input status, output ready);
endinterface

FILE: design/sha256_byte_stream_hasher.sv
// SHA-256 hasher over a byte stream.
// in_ch beats carry action and data_byte: action 0 absorbs one message byte,
// action 1 closes the message and returns its digest. out_ch beats carry one
// digest word each, word_index 0 to 7, last_word set on word 7; a refused
// byte (message already 2^61-1 bytes long) returns a single beat with
// status 1, last_word 1 and a zero word.
// Rate: in_ch.ready is high only while the sequencer is idle. An absorb that
// does not fill the block leaves the sequencer idle; the 64th byte of a block
// starts the compression (one round a cycle on the shared round datapath, then
// the hash update). A finish writes the padding one byte a cycle into the block
// window and then loads the round registers, runs one or two compressions, then
// loads the eight digest words into the output register, one a cycle while
// out_ch takes them.
// Reset (arst_n low) restores the initial hash, empties the block and clears
// the length. When out_ch stalls, the output register holds its word and the
// sequencer waits; absorbs are still taken while a result waits.
`include "assert_macros.svh"

module sha256_byte_stream_hasher
	import sha_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	sha_in_if.sink      in_ch,
	sha_out_if.source   out_ch
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_UPD,
		ST_OUT,
		ST_ERR
	} state_t;

	state_t             state_q;
	logic [WORD_W-1:0]  win_q  [WIN_N];
	logic [WORD_W-1:0]  wv_q   [HASH_N];
	logic [WORD_W-1:0]  hash_q [HASH_N];
	logic [FILL_W-1:0]  fill_q;
	logic [MSG_W-1:0]   msg_q;
	logic [5:0]         round_q;
	logic               fin_q;
	logic               len_ok_q;
	logic [2:0]         oidx_q;

	logic               out_valid_q;
	logic [WORD_W-1:0]  out_word_q;
	logic [2:0]         out_idx_q;
	logic               out_last_q;
	logic               out_status_q;

	logic               in_acc;
	logic               at_limit;
	logic               out_free;
	logic               wr_en;
	logic [BYTE_W-1:0]  wr_byte;
	logic [1:0]         wr_lane;
	logic               load_wv;
	logic [63:0]        len_bits;
	logic [BYTE_W-1:0]  len_byte;
	logic [WORD_W-1:0]  t1;
	logic [WORD_W-1:0]  t2;
	logic [WORD_W-1:0]  ch;
	logic [WORD_W-1:0]  mj;
	logic [WORD_W-1:0]  w_next;

	assign in_ch.ready        = (state_q == ST_IDLE);
	assign in_acc             = in_ch.valid && in_ch.ready;
	assign at_limit           = &msg_q;
	assign out_free           = !out_valid_q || out_ch.ready;

	assign out_ch.valid       = out_valid_q;
	assign out_ch.digest_word = out_word_q;
	assign out_ch.word_index  = out_idx_q;
	assign out_ch.last_word   = out_last_q;
	assign out_ch.status      = out_status_q;

	// Length field: message bytes times eight, big-endian over bytes 56..63.
	assign len_bits = {msg_q, 3'b000};
	assign len_byte = len_bits[{~fill_q[2:0], 3'b000} +: BYTE_W];
	assign wr_lane  = ~fill_q[1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_byte = '0;
		if (in_acc && in_ch.action) begin
			wr_en   = 1'b1;
			wr_byte = PAD_BYTE;
		end else if (in_acc && !at_limit) begin
			wr_en   = 1'b1;
			wr_byte = in_ch.data_byte;
		end else if (state_q == ST_PAD && fill_q != BLOCK_BYTES) begin
			wr_en   = 1'b1;
			wr_byte = (len_ok_q && fill_q >= LEN_POS) ? len_byte : '0;
		end
	end

	assign load_wv = (in_acc && !in_ch.action && !at_limit && fill_q == BLOCK_BYTES - 7'd1)
		|| (state_q == ST_PAD && fill_q == BLOCK_BYTES);

	// One round of the compression, with the schedule word sixteen ahead.
	assign ch     = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
	assign mj     = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
	assign t1     = wv_q[7] + big_sigma1(wv_q[4]) + ch + ROUND_K[round_q] + win_q[0];
	assign t2     = big_sigma0(wv_q[0]) + mj;
	assign w_next = win_q[0] + small_sigma0(win_q[1]) + win_q[9] + small_sigma1(win_q[14]);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			win_q[fill_q[5:2]][{wr_lane, 3'b000} +: BYTE_W] <= wr_byte;
		end else if (state_q == ST_COMP) begin
			for (int i = 0; i < WIN_N - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[WIN_N - 1] <= w_next;
		end

		if (load_wv) begin
			wv_q <= hash_q;
		end else if (state_q == ST_COMP) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			hash_q       <= INIT_H;
			fill_q       <= '0;
			msg_q        <= '0;
			round_q      <= '0;
			fin_q        <= 1'b0;
			len_ok_q     <= 1'b0;
			oidx_q       <= '0;
			out_valid_q  <= 1'b0;
			out_word_q   <= '0;
			out_idx_q    <= '0;
			out_last_q   <= 1'b0;
			out_status_q <= 1'b0;
		end else begin
			// drop valid once taken; the emit states reload the register themselves
			if (out_ch.valid && out_ch.ready && state_q != ST_OUT && state_q != ST_ERR) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && in_ch.action) begin
						fin_q    <= 1'b1;
						len_ok_q <= (fill_q < LEN_POS);
						fill_q   <= fill_q + 7'd1;
						state_q  <= ST_PAD;
					end else if (in_acc && at_limit) begin
						state_q <= ST_ERR;
					end else if (in_acc) begin
						fill_q <= fill_q + 7'd1;
						msg_q  <= msg_q + 61'd1;
						if (fill_q == BLOCK_BYTES - 7'd1) begin
							round_q <= '0;
							state_q <= ST_COMP;
						end
					end
				end
				ST_PAD: begin
					if (fill_q == BLOCK_BYTES) begin
						round_q <= '0;
						state_q <= ST_COMP;
					end else begin
						fill_q <= fill_q + 7'd1;
					end
				end
				ST_COMP: begin
					round_q <= round_q + 6'd1;
					if (&round_q) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					for (int i = 0; i < HASH_N; i++) begin
						hash_q[i] <= hash_q[i] + wv_q[i];
					end
					fill_q <= '0;
					if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (!len_ok_q) begin
						// pad block overflowed: length goes in one more block
						len_ok_q <= 1'b1;
						state_q  <= ST_PAD;
					end else begin
						oidx_q  <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_word_q   <= hash_q[oidx_q];
						out_idx_q    <= oidx_q;
						out_last_q   <= &oidx_q;
						out_status_q <= 1'b0;
						oidx_q       <= oidx_q + 3'd1;
						if (&oidx_q) begin
							hash_q  <= INIT_H;
							fill_q  <= '0;
							msg_q   <= '0;
							fin_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_ERR: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_word_q   <= '0;
						out_idx_q    <= '0;
						out_last_q   <= 1'b1;
						out_status_q <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`CHECK_PROP(a_err_beat_shape, clk, arst_n,
		(out_valid_q && out_status_q) |-> (out_last_q && out_word_q == '0 && out_idx_q == '0),
		"error beat must be a zero last word")
	`CHECK_NEVER(a_fill_range, clk, arst_n, fill_q > BLOCK_BYTES, "block fill beyond 64 bytes")
	`CHECK_PROP(a_digest_burst, clk, arst_n,
		(out_ch.valid && out_ch.ready && !out_ch.last_word) |=> out_ch.valid,
		"digest words must follow without a gap")
	`CHECK_PROP(a_finish_busy, clk, arst_n,
		(in_acc && in_ch.action) |=> !in_ch.ready,
		"finish must hold off new input")

endmodule
